/* rtl/core/ata_rd_pkg.sv */
`default_nettype none

package ata_rd_pkg;

    // Field widths
    localparam int MODE_W   = 2;
    localparam int LBA_W    = 28;
    localparam int COUNT_W  = 8;
    localparam int STATUS_W = 8;
    localparam int WORD_W   = 16;
    localparam int KIND_W   = 2;
    localparam int OFFS_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int ERR_W    = 3;
    localparam int LIMIT_W  = 20;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = LIMIT_W;

    // Sector geometry
    localparam int WORDS_PER_SECTOR = 256;
    localparam int WORD_IDX_W       = $clog2(WORDS_PER_SECTOR);

    // Input modes
    localparam logic [MODE_W-1:0] MODE_START  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STATUS = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DATA   = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FAIL  = 2'd3;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE        = 3'd0;
    localparam logic [ERR_W-1:0] ERR_NOT_PRESENT = 3'd1;
    localparam logic [ERR_W-1:0] ERR_BSY_TIMEOUT = 3'd2;
    localparam logic [ERR_W-1:0] ERR_DEVICE      = 3'd3;
    localparam logic [ERR_W-1:0] ERR_DRQ_TIMEOUT = 3'd4;

    // Task-file register offsets
    localparam logic [OFFS_W-1:0] TF_FEATURES = 3'd1;
    localparam logic [OFFS_W-1:0] TF_COUNT    = 3'd2;
    localparam logic [OFFS_W-1:0] TF_LBA0     = 3'd3;
    localparam logic [OFFS_W-1:0] TF_LBA1     = 3'd4;
    localparam logic [OFFS_W-1:0] TF_LBA2     = 3'd5;
    localparam logic [OFFS_W-1:0] TF_DRIVE    = 3'd6;
    localparam logic [OFFS_W-1:0] TF_COMMAND  = 3'd7;

    // Task-file values and status bits
    localparam logic [BYTE_W-1:0] DRIVE_LBA_MODE   = 8'hE0;
    localparam logic [BYTE_W-1:0] CMD_READ_SECTORS = 8'h20;
    localparam int ST_BSY_BIT = 7;
    localparam int ST_DRQ_BIT = 3;
    localparam int ST_ERR_BIT = 0;

    // Configuration registers
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_PRESENT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT     = 1'd1;
    localparam logic [LIMIT_W-1:0]   POLL_LIMIT_RESET   = 20'd1000000;

endpackage

`default_nettype wire

/* rtl/core/ata_rd_ifs.sv */
`default_nettype none

// Request channel: start, status sample or data word
interface ata_rd_req_if;
    logic                              valid;
    logic                              ready;
    logic [ata_rd_pkg::MODE_W-1:0]     mode;
    logic [ata_rd_pkg::LBA_W-1:0]      lba;
    logic [ata_rd_pkg::COUNT_W-1:0]    count;
    logic [ata_rd_pkg::STATUS_W-1:0]   status;
    logic [ata_rd_pkg::WORD_W-1:0]     data_in;

    modport source (output valid, mode, lba, count, status, data_in, input ready);
    modport sink   (input valid, mode, lba, count, status, data_in, output ready);
endinterface

// Result channel
interface ata_rd_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [ata_rd_pkg::KIND_W-1:0]     kind;
    logic [ata_rd_pkg::OFFS_W-1:0]     reg_offset;
    logic [ata_rd_pkg::BYTE_W-1:0]     reg_value;
    logic [ata_rd_pkg::WORD_W-1:0]     data_out;
    logic [ata_rd_pkg::ERR_W-1:0]      error_code;
    logic                              last;

    modport source (output valid, kind, reg_offset, reg_value, data_out, error_code, last,
                    input ready);
    modport sink   (input valid, kind, reg_offset, reg_value, data_out, error_code, last,
                    output ready);
endinterface

// Configuration write channel
interface ata_rd_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [ata_rd_pkg::CFG_IDX_W-1:0]    index;
    logic [ata_rd_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/ata_pio_read_sequencer_unit.sv */
// Latency: the first result of a request is registered and shown in the cycle after the request is taken.
// Throughput: one request per cycle while results are accepted; a request that causes n results holds the input
//   until the result register has played them out and the last is taken (n is at most 7).
// A result still waiting holds off every request, even one that causes no result.
// Reset: phase idle, counters and address cleared, no result pending,
//   device_present cleared and poll_limit set to 1000000; config writes taken every cycle.
`default_nettype none

module ata_pio_read_sequencer_unit (
    input  wire              clk,
    input  wire              rst_n,
    ata_rd_req_if.sink       req,
    ata_rd_rsp_if.source     rsp,
    ata_rd_cfg_if.sink       cfg
);

    // Phase codes
    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_WAIT_BSY = 2'd1;
    localparam logic [1:0] PH_WAIT_DRQ = 2'd2;
    localparam logic [1:0] PH_DATA     = 2'd3;

    // Result burst codes
    localparam logic [1:0] BURST_FAIL   = 2'd0;
    localparam logic [1:0] BURST_WRITES = 2'd1;
    localparam logic [1:0] BURST_DATA   = 2'd2;

    localparam logic [2:0] BEAT_LAST_WRITE = 3'd6;
    localparam logic [ata_rd_pkg::WORD_IDX_W-1:0] WORD_IDX_MAX =
        ata_rd_pkg::WORD_IDX_W'(ata_rd_pkg::WORDS_PER_SECTOR - 1);

    // Configuration registers
    logic                              device_present_reg;
    logic [ata_rd_pkg::LIMIT_W-1:0]    poll_limit_reg;

    // Sequencer state
    logic [1:0]                        phase_reg, phase_next;
    logic [ata_rd_pkg::LBA_W-1:0]      start_address_reg, start_address_next;
    logic [ata_rd_pkg::COUNT_W-1:0]    sector_total_reg, sector_total_next;
    logic [ata_rd_pkg::COUNT_W-1:0]    sectors_done_reg, sectors_done_next;
    logic [ata_rd_pkg::WORD_IDX_W-1:0] word_index_reg, word_index_next;
    logic [ata_rd_pkg::LIMIT_W-1:0]    poll_count_reg, poll_count_next;

    // Result burst register
    logic                              bvalid_reg, bvalid_next;
    logic [2:0]                        beat_reg, beat_next;
    logic [1:0]                        bkind_reg;
    logic [ata_rd_pkg::ERR_W-1:0]      berr_reg;
    logic                              bdone_reg;
    logic [ata_rd_pkg::LBA_W-1:0]      blba_reg;
    logic [ata_rd_pkg::COUNT_W-1:0]    bcount_reg;
    logic [ata_rd_pkg::WORD_W-1:0]     bword_reg;

    // Burst descriptor built for the request being taken
    logic                              nb_gen;
    logic [1:0]                        nb_kind;
    logic [ata_rd_pkg::ERR_W-1:0]      nb_err;
    logic                              nb_done;

    logic                              req_acc;
    logic                              rsp_acc;
    logic                              beat_last;
    logic [ata_rd_pkg::LIMIT_W-1:0]    poll_inc;
    logic                              poll_expired;
    logic [ata_rd_pkg::COUNT_W-1:0]    sectors_inc;
    logic                              st_bsy, st_drq, st_err;

    // Handshakes
    assign rsp_acc   = bvalid_reg && rsp.ready;
    assign req.ready = !bvalid_reg || (rsp.ready && beat_last);
    assign req_acc   = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign st_bsy       = req.status[ata_rd_pkg::ST_BSY_BIT];
    assign st_drq       = req.status[ata_rd_pkg::ST_DRQ_BIT];
    assign st_err       = req.status[ata_rd_pkg::ST_ERR_BIT];
    assign poll_inc     = poll_count_reg + 1'b1;
    assign poll_expired = (poll_inc >= poll_limit_reg);
    assign sectors_inc  = sectors_done_reg + 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_present_reg <= 1'b0;
            poll_limit_reg     <= ata_rd_pkg::POLL_LIMIT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                ata_rd_pkg::CFG_DEVICE_PRESENT: device_present_reg <= cfg.data[0];
                ata_rd_pkg::CFG_POLL_LIMIT:     poll_limit_reg     <= cfg.data;
                default: ;
            endcase
        end
    end

    // Sequencer next state and burst descriptor
    always_comb
    begin
        phase_next         = phase_reg;
        start_address_next = start_address_reg;
        sector_total_next  = sector_total_reg;
        sectors_done_next  = sectors_done_reg;
        word_index_next    = word_index_reg;
        poll_count_next    = poll_count_reg;
        nb_gen             = 1'b0;
        nb_kind            = BURST_FAIL;
        nb_err             = ata_rd_pkg::ERR_NONE;
        nb_done            = 1'b0;

        if (req_acc)
        begin
            unique case (req.mode)
                ata_rd_pkg::MODE_START:
                begin
                    if (!device_present_reg)
                    begin
                        phase_next      = PH_IDLE;
                        poll_count_next = '0;
                        nb_gen          = 1'b1;
                        nb_err          = ata_rd_pkg::ERR_NOT_PRESENT;
                    end
                    else
                    begin
                        start_address_next = req.lba;
                        sector_total_next  = (req.count == '0) ? 8'd1 : req.count;
                        sectors_done_next  = '0;
                        word_index_next    = '0;
                        poll_count_next    = '0;
                        phase_next         = PH_WAIT_BSY;
                    end
                end
                ata_rd_pkg::MODE_STATUS:
                begin
                    unique case (phase_reg)
                        PH_WAIT_BSY:
                        begin
                            if (!st_bsy)
                            begin
                                phase_next      = PH_WAIT_DRQ;
                                poll_count_next = '0;
                                nb_gen          = 1'b1;
                                nb_kind         = BURST_WRITES;
                            end
                            else if (poll_expired)
                            begin
                                phase_next      = PH_IDLE;
                                poll_count_next = '0;
                                nb_gen          = 1'b1;
                                nb_err          = ata_rd_pkg::ERR_BSY_TIMEOUT;
                            end
                            else
                            begin
                                poll_count_next = poll_inc;
                            end
                        end
                        PH_WAIT_DRQ:
                        begin
                            if (st_err)
                            begin
                                phase_next      = PH_IDLE;
                                poll_count_next = '0;
                                nb_gen          = 1'b1;
                                nb_err          = ata_rd_pkg::ERR_DEVICE;
                            end
                            else if (!st_bsy && st_drq)
                            begin
                                phase_next      = PH_DATA;
                                word_index_next = '0;
                                poll_count_next = '0;
                            end
                            else if (poll_expired)
                            begin
                                phase_next      = PH_IDLE;
                                poll_count_next = '0;
                                nb_gen          = 1'b1;
                                nb_err          = ata_rd_pkg::ERR_DRQ_TIMEOUT;
                            end
                            else
                            begin
                                poll_count_next = poll_inc;
                            end
                        end
                        default: ;
                    endcase
                end
                ata_rd_pkg::MODE_DATA:
                begin
                    if (phase_reg == PH_DATA)
                    begin
                        nb_gen  = 1'b1;
                        nb_kind = BURST_DATA;
                        if (word_index_reg == WORD_IDX_MAX)
                        begin
                            word_index_next   = '0;
                            sectors_done_next = sectors_inc;
                            poll_count_next   = '0;
                            if (sectors_inc >= sector_total_reg)
                            begin
                                phase_next = PH_IDLE;
                                nb_done    = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_WAIT_DRQ;
                            end
                        end
                        else
                        begin
                            word_index_next = word_index_reg + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Burst control
    always_comb
    begin
        bvalid_next = bvalid_reg;
        beat_next   = beat_reg;
        if (req_acc)
        begin
            bvalid_next = nb_gen;
            beat_next   = '0;
        end
        else if (rsp_acc)
        begin
            if (beat_last)
                bvalid_next = 1'b0;
            else
                beat_next = beat_reg + 1'b1;
        end
    end

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            start_address_reg <= '0;
            sector_total_reg  <= '0;
            sectors_done_reg  <= '0;
            word_index_reg    <= '0;
            poll_count_reg    <= '0;
            bvalid_reg        <= 1'b0;
            beat_reg          <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            start_address_reg <= start_address_next;
            sector_total_reg  <= sector_total_next;
            sectors_done_reg  <= sectors_done_next;
            word_index_reg    <= word_index_next;
            poll_count_reg    <= poll_count_next;
            bvalid_reg        <= bvalid_next;
            beat_reg          <= beat_next;
        end
    end

    // Burst payload, loaded with each request taken
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            bkind_reg  <= nb_kind;
            berr_reg   <= nb_err;
            bdone_reg  <= nb_done;
            blba_reg   <= start_address_reg;
            bcount_reg <= sector_total_reg;
            bword_reg  <= req.data_in;
        end
    end

    // Result decode from burst and beat
    always_comb
    begin
        rsp.kind       = ata_rd_pkg::KIND_FAIL;
        rsp.reg_offset = '0;
        rsp.reg_value  = '0;
        rsp.data_out   = '0;
        rsp.error_code = '0;
        beat_last      = 1'b1;
        unique case (bkind_reg)
            BURST_WRITES:
            begin
                rsp.kind  = ata_rd_pkg::KIND_WRITE;
                beat_last = (beat_reg == BEAT_LAST_WRITE);
                case (beat_reg)
                    3'd0:
                    begin
                        rsp.reg_offset = ata_rd_pkg::TF_DRIVE;
                        rsp.reg_value  = ata_rd_pkg::DRIVE_LBA_MODE | {4'b0, blba_reg[27:24]};
                    end
                    3'd1: rsp.reg_offset = ata_rd_pkg::TF_FEATURES;
                    3'd2:
                    begin
                        rsp.reg_offset = ata_rd_pkg::TF_COUNT;
                        rsp.reg_value  = bcount_reg;
                    end
                    3'd3:
                    begin
                        rsp.reg_offset = ata_rd_pkg::TF_LBA0;
                        rsp.reg_value  = blba_reg[7:0];
                    end
                    3'd4:
                    begin
                        rsp.reg_offset = ata_rd_pkg::TF_LBA1;
                        rsp.reg_value  = blba_reg[15:8];
                    end
                    3'd5:
                    begin
                        rsp.reg_offset = ata_rd_pkg::TF_LBA2;
                        rsp.reg_value  = blba_reg[23:16];
                    end
                    default:
                    begin
                        rsp.reg_offset = ata_rd_pkg::TF_COMMAND;
                        rsp.reg_value  = ata_rd_pkg::CMD_READ_SECTORS;
                    end
                endcase
            end
            BURST_DATA:
            begin
                // data word, then done when the final sector completes
                if (beat_reg == 3'd0)
                begin
                    rsp.kind     = ata_rd_pkg::KIND_DATA;
                    rsp.data_out = bword_reg;
                    beat_last    = !bdone_reg;
                end
                else
                begin
                    rsp.kind = ata_rd_pkg::KIND_DONE;
                end
            end
            default:
            begin
                rsp.kind       = ata_rd_pkg::KIND_FAIL;
                rsp.error_code = berr_reg;
            end
        endcase
    end

    assign rsp.valid = bvalid_reg;
    assign rsp.last  = beat_last;

    // Checks
    a_done_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.kind == ata_rd_pkg::KIND_DONE) |-> (phase_reg == PH_IDLE))
        else $error("done result while a command is still running");

    a_writes_wait_drq: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.kind == ata_rd_pkg::KIND_WRITE) |-> (phase_reg == PH_WAIT_DRQ))
        else $error("task-file write while not waiting for DRQ");

    a_fail_has_code: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.kind == ata_rd_pkg::KIND_FAIL) |->
            (rsp.error_code != ata_rd_pkg::ERR_NONE && rsp.last))
        else $error("failure result without code or not final");

    a_beat_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(beat_reg)))
        else $error("burst moved on while result stalled");

endmodule

`default_nettype wire
